/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL. They expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/csfd_pkg.sv */
`timescale 1ns / 1ps

package csfd_pkg;

	// Field widths.
	localparam int ID_W     = 29;
	localparam int ADDR_W   = 8;
	localparam int PAYLD_W  = 64;
	localparam int TICK_W   = 32;
	localparam int CFG_W    = 32;
	localparam int NUM_SRC  = 6;
	localparam int IN_W     = 128;
	localparam int OUT_W    = 224;

	localparam logic [TICK_W-1:0] STALE_LIMIT_RESET = 32'd1000;

	// Source slots, in the bit order of valid_flags.
	localparam int SRC_COUNTER = 0;
	localparam int SRC_VALVE   = 1;
	localparam int SRC_ANALOG  = 2;
	localparam int SRC_TIME    = 3;
	localparam int SRC_CARD    = 4;
	localparam int SRC_MASTER  = 5;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ANALOG_ID   = 3'd0,
		REG_COUNTER_ID  = 3'd1,
		REG_TIME_ID     = 3'd2,
		REG_VALVE_ID    = 3'd3,
		REG_CARD_ID     = 3'd4,
		REG_MASTER_ID   = 3'd5,
		REG_STALE_LIMIT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_SRC-1:0][ID_W-1:0] src_id;
		logic [TICK_W-1:0]            stale_limit;
	} cfg_t;

	// Declared from the top bit down so that analog_one lands in the lowest bits.
	typedef struct packed {
		logic [NUM_SRC-1:0] valid_flags;
		logic [63:0]        master_bytes;
		logic [39:0]        card_bytes;
		logic               valve_on;
		logic               pump_on;
		logic [31:0]        remote_time;
		logic [31:0]        external_count;
		logic [15:0]        analog_three;
		logic [15:0]        analog_two;
		logic [15:0]        analog_one;
	} result_t;

endpackage

/* hw/rtl/csfd_cfg.sv */
`timescale 1ns / 1ps

module csfd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [csfd_pkg::CFG_W-1:0] cfg_data,
	output csfd_pkg::cfg_t             cfg
);
	import csfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_id      <= '0;
			cfg_q.stale_limit <= STALE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ANALOG_ID:   cfg_q.src_id[SRC_ANALOG]  <= cfg_data[ID_W-1:0];
				REG_COUNTER_ID:  cfg_q.src_id[SRC_COUNTER] <= cfg_data[ID_W-1:0];
				REG_TIME_ID:     cfg_q.src_id[SRC_TIME]    <= cfg_data[ID_W-1:0];
				REG_VALVE_ID:    cfg_q.src_id[SRC_VALVE]   <= cfg_data[ID_W-1:0];
				REG_CARD_ID:     cfg_q.src_id[SRC_CARD]    <= cfg_data[ID_W-1:0];
				REG_MASTER_ID:   cfg_q.src_id[SRC_MASTER]  <= cfg_data[ID_W-1:0];
				REG_STALE_LIMIT: cfg_q.stale_limit         <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/csfd_record.sv */
`timescale 1ns / 1ps

module csfd_record (
	input  logic                              clk,
	input  logic                              arst_n,
	input  csfd_pkg::cfg_t                    cfg,
	input  logic                              upd_en,
	input  logic [csfd_pkg::ID_W-1:0]         frame_id,
	input  logic [csfd_pkg::PAYLD_W-1:0]      payload,
	input  logic [csfd_pkg::TICK_W-1:0]       now_tick,
	output logic                              addr_hit,
	output logic [csfd_pkg::NUM_SRC-1:0]      id_hit,
	output csfd_pkg::result_t                 result
);
	import csfd_pkg::*;

	result_t                   rec_q;
	result_t                   rec_d;
	logic [TICK_W-1:0]         last_seen_q [NUM_SRC];
	logic [TICK_W-1:0]         last_seen_d [NUM_SRC];
	logic [NUM_SRC-1:0][TICK_W:0] expire_at;
	logic [NUM_SRC-1:0]        stale;

	always_comb begin
		addr_hit = 1'b0;
		for (int i = 0; i < NUM_SRC; i++) begin
			id_hit[i] = (frame_id == cfg.src_id[i]);
			if (frame_id[ADDR_W-1:0] == cfg.src_id[i][ADDR_W-1:0]) begin
				addr_hit = 1'b1;
			end
		end

		rec_d = rec_q;
		if (id_hit[SRC_ANALOG]) begin
			rec_d.analog_one   = payload[15:0];
			rec_d.analog_two   = payload[31:16];
			rec_d.analog_three = payload[47:32];
		end
		if (id_hit[SRC_COUNTER]) begin
			rec_d.external_count = payload[31:0];
		end
		if (id_hit[SRC_TIME]) begin
			rec_d.remote_time = payload[63:32];
		end
		if (id_hit[SRC_VALVE]) begin
			rec_d.pump_on  = (payload[15:8] != 8'h00);
			rec_d.valve_on = (payload[55:48] == 8'h00);
		end
		if (id_hit[SRC_CARD]) begin
			rec_d.card_bytes = payload[55:16];
		end
		if (id_hit[SRC_MASTER]) begin
			rec_d.master_bytes = payload;
		end

		// Expiry is judged on the updated last-seen ticks; the sum is one bit wider
		// so it never wraps.
		for (int i = 0; i < NUM_SRC; i++) begin
			last_seen_d[i] = id_hit[i] ? now_tick : last_seen_q[i];
			expire_at[i]   = {1'b0, last_seen_d[i]} + {1'b0, cfg.stale_limit};
			stale[i]       = ({1'b0, now_tick} > expire_at[i]);
		end
		rec_d.valid_flags = (rec_q.valid_flags | id_hit) & ~stale;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
			for (int i = 0; i < NUM_SRC; i++) begin
				last_seen_q[i] <= '0;
			end
		end else if (upd_en) begin
			rec_q <= rec_d;
			for (int i = 0; i < NUM_SRC; i++) begin
				last_seen_q[i] <= last_seen_d[i];
			end
		end
	end

	assign result = rec_d;

endmodule

/* hw/rtl/can_sensor_frame_dispatcher_top.sv */
`timescale 1ns / 1ps

// CAN sensor frame dispatcher. Each input transaction carries one received extended CAN
// frame (29-bit identifier, eight data bytes) and the current tick. When the frame's
// source address (low eight identifier bits) equals the address of any of the six
// configured source identifiers, the frame is taken: every source whose full identifier
// matches updates its record, its valid flag and its last-seen tick, then every source
// whose last-seen tick plus the stale limit is below the current tick loses its valid flag,
// and one output transaction carries the whole record. A frame whose address matches no
// source changes nothing and produces no output transaction. The block takes one input
// transaction per clock cycle while the downstream side keeps taking results; a result
// passes through the input register, the combinational update logic and the output
// register. While one result waits for the downstream side, the input register can still
// take one more frame; after that the input side stalls until the result is taken.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle, which the block itself does not enforce.
// Index 0 to 5 are the analog, counter, time, valve, card and master source identifiers
// (reset 0), index 6 is the stale limit in ticks (reset 1000); other indexes are ignored.

`include "assert_macros.svh"

module can_sensor_frame_dispatcher_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input frames.
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: frame_id [28:0], payload [92:29], now_tick [124:93], zero [127:125]
	input  logic [csfd_pkg::IN_W-1:0]  s_axis_tdata,
	// Results.
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// tdata: analog_one [15:0], analog_two [31:16], analog_three [47:32],
	// external_count [79:48], remote_time [111:80], pump_on [112], valve_on [113],
	// card_bytes [153:114], master_bytes [217:154], valid_flags [223:218]
	output logic [csfd_pkg::OUT_W-1:0] m_axis_tdata,
	// Configuration write port.
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [csfd_pkg::CFG_W-1:0] cfg_data
);
	import csfd_pkg::*;

	cfg_t                cfg;

	// Input register.
	logic                valid_s1;
	logic [ID_W-1:0]     frame_id_s1;
	logic [PAYLD_W-1:0]  payload_s1;
	logic [TICK_W-1:0]   now_tick_s1;

	// Output register.
	logic                out_valid_q;
	result_t             out_data_q;

	logic                advance;
	logic                in_fire;
	logic                upd_en;
	logic                addr_hit;
	logic [NUM_SRC-1:0]  id_hit;
	result_t             result;

	// The input register moves on whenever the output register is empty or being drained,
	// so an empty input register always takes a new transaction.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Only frames whose address matches a source commit state and produce a result.
	assign upd_en = valid_s1 && advance && addr_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			frame_id_s1 <= s_axis_tdata[ID_W-1:0];
			payload_s1  <= s_axis_tdata[ID_W+PAYLD_W-1:ID_W];
			now_tick_s1 <= s_axis_tdata[ID_W+PAYLD_W+TICK_W-1:ID_W+PAYLD_W];
		end
	end

	csfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	csfd_record u_record (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.upd_en   (upd_en),
		.frame_id (frame_id_s1),
		.payload  (payload_s1),
		.now_tick (now_tick_s1),
		.addr_hit (addr_hit),
		.id_hit   (id_hit),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= upd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// An empty input register never refuses a transaction.
	`ASSERT_SAME(a_ready_when_empty, clk, arst_n, !valid_s1, s_axis_tready,
		"input register empty but tready low")

	// A frame that matches no source address must not create a result.
	`ASSERT_NEXT(a_no_result_on_miss, clk, arst_n,
		advance && !(valid_s1 && addr_hit), !out_valid_q,
		"result produced without an address match")

	// Every source whose identifier matched the committed frame reports valid.
	`ASSERT_NEXT(a_hit_sets_valid, clk, arst_n, upd_en,
		(out_data_q.valid_flags & $past(id_hit)) == $past(id_hit),
		"matched source not flagged valid")

endmodule
